@@ rtl/core/act_pkg.sv @@
// Shared types and constants for the angle command tokenizer.
package act_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_OPEN  = 8'h3C;
    localparam logic [7:0]  CH_CLOSE = 8'h3E;
    localparam logic [7:0]  CH_QUOTE = 8'h22;
    localparam logic [7:0]  CH_INFO  = 8'h69;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_UNDER = 8'h5F;

    localparam logic [19:0] TEXT_MARK_HI = 20'h77777;
    localparam logic [31:0] TEXT_MARK    = 32'h7777_7000;

    localparam logic [6:0]  MAX_PARAMS_RESET = 7'd16;
    localparam int unsigned REG_MAX_PARAMS   = 0;

    typedef enum logic [1:0] {
        KIND_PARAM   = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_NO_TERM = 2'd2,
        KIND_FAIL    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_FIND   = 3'd0,
        PH_OPCODE = 3'd1,
        PH_SKIP   = 3'd2,
        PH_SIGN   = 3'd3,
        PH_BUILD  = 3'd4,
        PH_TEXT   = 3'd5,
        PH_ITEXT  = 3'd6
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  idx;
        logic [31:0] value;
    } t_result;

    typedef struct packed {
        logic [1:0]    count;
        logic [7:0]    opcode;
        t_result [2:0] res;
    } t_bundle;

endpackage

@@ rtl/core/act_front.sv @@
// Byte parser: classifies each byte and builds the bundle of results it causes.
module act_front import act_pkg::*; #(
    parameter int unsigned MAX_PARAMS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_ch,
    input  logic       i_first,
    input  logic [6:0] i_max_params,
    output logic       o_push,
    output t_bundle    o_bundle
);

    localparam logic [6:0] LIMIT_CAP = 7'(MAX_PARAMS);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_opcode, n_opcode;
    logic [31:0] r_running, n_running;
    logic        r_negative, n_negative;
    logic [6:0]  r_count, n_count;
    logic [11:0] r_position, n_position;
    logic        r_finished, n_finished;

    logic [6:0]  limit;
    logic        is_digit, is_alpha, is_word;
    logic [7:0]  upper;
    logic [31:0] digit_val, upper_val, text_val, end_val;
    logic        active;
    logic        skip_go;
    logic [1:0]  k;
    t_bundle     bundle;

    assign limit     = (i_max_params > LIMIT_CAP) ? LIMIT_CAP : i_max_params;
    assign is_digit  = (i_ch >= 8'h30) && (i_ch <= 8'h39);
    assign is_alpha  = ((i_ch >= 8'h61) && (i_ch <= 8'h7A)) ||
                       ((i_ch >= 8'h41) && (i_ch <= 8'h5A));
    assign is_word   = is_digit || is_alpha || (i_ch == CH_UNDER);
    assign upper     = ((i_ch >= 8'h61) && (i_ch <= 8'h7A)) ? (i_ch - 8'h20) : i_ch;
    assign digit_val = {24'd0, i_ch - 8'h30};
    assign upper_val = {24'd0, upper};
    assign active    = i_first || !r_finished;

    always_comb begin
        n_phase    = i_first ? PH_FIND : r_phase;
        n_opcode   = i_first ? 8'd0 : r_opcode;
        n_running  = i_first ? 32'd0 : r_running;
        n_negative = i_first ? 1'b0 : r_negative;
        n_count    = i_first ? 7'd0 : r_count;
        n_position = i_first ? 12'd0 : r_position;
        n_finished = i_first ? 1'b0 : r_finished;
        text_val   = TEXT_MARK | {20'd0, n_position + 12'd1};
        end_val    = n_negative ? (32'd0 - n_running) : n_running;
        skip_go    = 1'b0;
        k          = 2'd0;
        bundle     = '0;

        if (active) begin
            if (n_count >= limit) begin
                bundle.res[0].kind = KIND_FAIL;
                k = 2'd1;
                n_finished = 1'b1;
            end else if (i_ch == CH_NUL) begin
                bundle.res[0].kind = KIND_NO_TERM;
                k = 2'd1;
                n_finished = 1'b1;
            end else begin
                unique case (n_phase)
                    PH_OPCODE: begin
                        n_opcode = i_ch;
                        if (i_ch == CH_INFO) begin
                            n_phase = PH_ITEXT;
                            bundle.res[k] = '{KIND_PARAM, n_count[5:0], text_val};
                            k = k + 2'd1;
                            n_count = n_count + 7'd1;
                            if (n_count >= limit) begin
                                bundle.res[k].kind = KIND_FAIL;
                                k = k + 2'd1;
                                n_finished = 1'b1;
                            end
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_ITEXT: begin
                        if (i_ch == CH_CLOSE) begin
                            bundle.res[k].kind = KIND_DONE;
                            k = k + 2'd1;
                            n_finished = 1'b1;
                        end
                    end
                    PH_TEXT: begin
                        if (i_ch == CH_QUOTE) begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP, PH_SIGN, PH_BUILD: begin
                        if (n_phase == PH_BUILD) begin
                            if (is_digit) begin
                                n_running = (n_running << 3) + (n_running << 1) + digit_val;
                            end else if (is_word) begin
                                n_running = ((n_running << 5) + n_running) ^ upper_val;
                            end else begin
                                bundle.res[k] = '{KIND_PARAM, n_count[5:0], end_val};
                                k = k + 2'd1;
                                n_count = n_count + 7'd1;
                                n_phase = PH_SKIP;
                                if (n_count >= limit) begin
                                    bundle.res[k].kind = KIND_FAIL;
                                    k = k + 2'd1;
                                    n_finished = 1'b1;
                                end else begin
                                    skip_go = 1'b1;
                                end
                            end
                        end
                        if ((n_phase == PH_SKIP) && (r_phase == PH_SKIP || skip_go || i_first)) begin
                            if (i_ch == CH_CLOSE) begin
                                bundle.res[k].kind = KIND_DONE;
                                k = k + 2'd1;
                                n_finished = 1'b1;
                            end else if (i_ch != CH_SPACE) begin
                                n_phase = PH_SIGN;
                            end
                        end
                        if ((n_phase == PH_SIGN) && !n_finished) begin
                            if (i_ch == CH_QUOTE) begin
                                n_phase = PH_TEXT;
                                bundle.res[k] = '{KIND_PARAM, n_count[5:0], text_val};
                                k = k + 2'd1;
                                n_count = n_count + 7'd1;
                                if (n_count >= limit) begin
                                    bundle.res[k].kind = KIND_FAIL;
                                    k = k + 2'd1;
                                    n_finished = 1'b1;
                                end
                            end else if (i_ch == CH_MINUS) begin
                                n_running  = 32'd0;
                                n_negative = 1'b1;
                                n_phase    = PH_BUILD;
                            end else if (is_word) begin
                                n_running  = is_digit ? digit_val : upper_val;
                                n_negative = 1'b0;
                                n_phase    = PH_BUILD;
                            end else begin
                                bundle.res[k].kind = KIND_FAIL;
                                k = k + 2'd1;
                                n_finished = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = (i_ch == CH_OPEN) ? PH_OPCODE : PH_FIND;
                    end
                endcase
            end
            n_position = n_position + 12'd1;
        end else begin
            n_phase    = r_phase;
            n_opcode   = r_opcode;
            n_running  = r_running;
            n_negative = r_negative;
            n_count    = r_count;
            n_position = r_position;
            n_finished = r_finished;
        end

        bundle.count  = k;
        bundle.opcode = n_opcode;
    end

    assign o_push   = i_accept && (k != 2'd0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIND;
            r_opcode   <= 8'd0;
            r_running  <= 32'd0;
            r_negative <= 1'b0;
            r_count    <= 7'd0;
            r_position <= 12'd0;
            r_finished <= 1'b1;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_running  <= n_running;
            r_negative <= n_negative;
            r_count    <= n_count;
            r_position <= n_position;
            r_finished <= n_finished;
        end
    end

endmodule

@@ rtl/core/act_queue.sv @@
// Short queue of result bundles between the parser and the result stage.
module act_queue import act_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_bundle o_bundle
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_bundle            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/core/act_back.sv @@
// Result stage: walks each bundle and presents its results one per transaction.
module act_back import act_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_bundle            i_q_bundle,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_opcode,
    output logic [5:0]         o_param_index,
    output logic signed [31:0] o_value,
    output logic               o_is_text,
    output logic               o_last
);

    logic       r_valid, n_valid;
    t_bundle    r_bundle;
    logic [1:0] r_sel, n_sel;
    logic       at_last, load;
    t_result    cur;

    assign cur     = r_bundle.res[r_sel];
    assign at_last = (r_sel == r_bundle.count - 2'd1);
    assign load    = (!r_valid || (i_pop && at_last)) && i_q_valid;
    assign o_q_pop = load;

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        if (load) begin
            n_valid = 1'b1;
            n_sel   = 2'd0;
        end else if (r_valid && i_pop) begin
            if (at_last) begin
                n_valid = 1'b0;
                n_sel   = 2'd0;
            end else begin
                n_sel = r_sel + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bundle <= i_q_bundle;
        end
    end

    assign o_empty       = !r_valid;
    assign o_kind        = cur.kind;
    assign o_opcode      = r_bundle.opcode;
    assign o_param_index = cur.idx;
    assign o_value       = cur.value;
    assign o_is_text     = (cur.value[31:12] == TEXT_MARK_HI);
    assign o_last        = at_last;

endmodule

@@ rtl/core/angle_command_tokenizer.sv @@
// Top level: command byte tokenizer with parser, bundle queue and result stage.
// A result passes from the parser into the bundle queue and is then loaded into
// the result stage register before it reaches the output ports.
// Throughput: one byte per cycle while full is low; one result per cycle, set by the single result stage.
// A byte causing several results holds the output for one pop per result; the
// 4-entry bundle queue absorbs bursts before full rises.
// Reset (synchronous, active low): idle until a byte with first set, limit 16.
module angle_command_tokenizer import act_pkg::*; #(
    parameter int unsigned MAX_PARAMS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_ch,
    input  logic               i_first,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_opcode,
    output logic [5:0]         o_param_index,
    output logic signed [31:0] o_value,
    output logic               o_is_text,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [6:0] r_max_params;
    logic       accept;
    logic       f_push;
    t_bundle    f_bundle;
    logic       q_valid, q_pop;
    t_bundle    q_bundle;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'(REG_MAX_PARAMS));
    assign prdata  = reg_hit ? {25'd0, r_max_params} : 32'd0;
    assign accept  = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_params <= MAX_PARAMS_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_max_params <= pwdata[6:0];
        end
    end

    act_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_ch         (i_ch),
        .i_first      (i_first),
        .i_max_params (r_max_params),
        .o_push       (f_push),
        .o_bundle     (f_bundle)
    );

    act_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_bundle (f_bundle),
        .i_pop    (q_pop),
        .o_full   (full),
        .o_valid  (q_valid),
        .o_bundle (q_bundle)
    );

    act_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_bundle    (q_bundle),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (o_kind),
        .o_opcode      (o_opcode),
        .o_param_index (o_param_index),
        .o_value       (o_value),
        .o_is_text     (o_is_text),
        .o_last        (o_last)
    );

endmodule
